>>> hdl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types, constants and codes of the first-fit heap block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int MaxBlocks   = 64;
  localparam int AddrW       = $clog2(MaxBlocks);
  localparam int CntW        = AddrW + 1;
  localparam int HeapBytes   = 65536;
  localparam int HeaderBytes = 40;
  localparam int GrowthFloor = 1024;
  localparam int GmW         = 17;
  localparam int SizeW       = 16;
  localparam int OffW        = 16;
  localparam int StW         = 3;
  localparam int InW         = 40;
  localparam int OutW        = 24;
  localparam int ChunkW      = 2 * GmW + 1;
  localparam int DivCntW     = $clog2(GmW + 1);
  localparam int GmLowVal    = (2 * HeaderBytes > GrowthFloor) ? 2 * HeaderBytes : GrowthFloor;

  localparam logic [GmW-1:0]  GmReset = GmW'(1024);
  localparam logic [OffW-1:0] NoBlock = {OffW{1'b1}};

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_RESET   = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK           = 3'd0,
    ST_NULL         = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_NO_SPACE     = 3'd4
  } status_e;

  typedef struct packed {
    logic             is_free;
    logic [SizeW-1:0] capacity;
    logic [SizeW-1:0] used;
    logic [OffW-1:0]  start;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RESET_HEAP,
    CMD_RES_NULL,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_REUSE,
    CMD_SPLIT_START,
    CMD_MOVE,
    CMD_SPLIT_NEW,
    CMD_SPLIT_OLD,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_MUL,
    CMD_APPEND,
    CMD_RES_NOSPACE,
    CMD_FIND_HIT,
    CMD_RES_NOTFOUND,
    CMD_RES_NOTFOUND_RA,
    CMD_RES_ALREADY,
    CMD_INPLACE,
    CMD_MARK_FREE,
    CMD_WR_CUR,
    CMD_PRV_RD,
    CMD_PRV_MERGE,
    CMD_NXT_RD,
    CMD_NXT_MERGE,
    CMD_RES_OK0,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    op_e  op;
    logic size_zero;
    logic boff_none;
    logic scan_end;
    logic reuse_hit;
    logic split_hit;
    logic find_hit;
    logic cur_free;
    logic cap_ge;
    logic f_zero;
    logic rd_free;
    logic nxt_exists;
    logic mv_busy;
    logic div_done;
    logic app_fail;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/first_fit_heap_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_block_allocator
// first-fit heap allocator with block split, coalesce and arena growth
// ----------------------------------------------------------------------------
// one word at a time; the time from accept to result valid grows with the number
//   of live entries: allocate scans the table, then shifts it for a split or runs the divider,
//   free and reallocate scan it too; all bound by the single table ram read port
// next word is accepted once the previous result sits in the output register
// reset clears entry count and heap top, growth granule returns to 1024;
// table ram is not cleared
`default_nettype none

module first_fit_heap_block_allocator (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // op[1:0], req_size[17:2], block_offset[33:18], zero pad
  input  wire logic [ffa_pkg::InW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // data_offset[15:0], status[18:16], zero pad
  output logic      [ffa_pkg::OutW-1:0] m_axis_tdata,
  input  wire logic                     cfg_we_i,
  input  wire logic [ffa_pkg::GmW-1:0]  cfg_wdata_i
);

  ffa_pkg::cmd_e     cmd;
  ffa_pkg::dp_stat_t stat;

  ffa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  ffa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

`default_nettype wire

>>> hdl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// sequencer for allocate, free, reallocate and heap reset requests
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire ffa_pkg::dp_stat_t stat_i,
  output ffa_pkg::cmd_e         cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_DISP   = 18'b000000000000000010,
    S_ACHK   = 18'b000000000000000100,
    S_MVS    = 18'b000000000000001000,
    S_SPO    = 18'b000000000000010000,
    S_DIV    = 18'b000000000000100000,
    S_APP    = 18'b000000000001000000,
    S_FSTART = 18'b000000000010000000,
    S_FCHK   = 18'b000000000100000000,
    S_FHIT   = 18'b000000001000000000,
    S_PRV    = 18'b000000010000000000,
    S_PCHK   = 18'b000000100000000000,
    S_MVP    = 18'b000001000000000000,
    S_NRD    = 18'b000010000000000000,
    S_NCHK   = 18'b000100000000000000,
    S_MVN    = 18'b001000000000000000,
    S_FEND   = 18'b010000000000000000,
    S_DONE   = 18'b100000000000000000
  } state_e;

  state_e state_q, state_d;
  logic   ra_q, ra_d;
  logic   post_q, post_d;

  always_comb begin
    state_d       = state_q;
    ra_d          = ra_q;
    post_d        = post_q;
    cmd_o         = ffa_pkg::CMD_NONE;
    s_axis_tready = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o   = ffa_pkg::CMD_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        ra_d   = 1'b0;
        post_d = 1'b0;
        case (stat_i.op)
          ffa_pkg::OP_RESET: begin
            cmd_o   = ffa_pkg::CMD_RESET_HEAP;
            state_d = S_DONE;
          end
          ffa_pkg::OP_FREE: begin
            cmd_o   = ffa_pkg::CMD_SCAN_START;
            state_d = S_FCHK;
          end
          ffa_pkg::OP_REALLOC: begin
            if (stat_i.size_zero) begin
              cmd_o   = ffa_pkg::CMD_RES_NULL;
              state_d = S_DONE;
            end else if (stat_i.boff_none) begin
              cmd_o   = ffa_pkg::CMD_SCAN_START;
              state_d = S_ACHK;
            end else begin
              cmd_o   = ffa_pkg::CMD_SCAN_START;
              ra_d    = 1'b1;
              state_d = S_FCHK;
            end
          end
          default: begin
            if (stat_i.size_zero) begin
              cmd_o   = ffa_pkg::CMD_RES_NULL;
              state_d = S_DONE;
            end else begin
              cmd_o   = ffa_pkg::CMD_SCAN_START;
              state_d = S_ACHK;
            end
          end
        endcase
      end
      S_ACHK: begin
        if (stat_i.scan_end) begin
          cmd_o   = ffa_pkg::CMD_DIV_START;
          state_d = S_DIV;
        end else if (stat_i.reuse_hit) begin
          cmd_o   = ffa_pkg::CMD_REUSE;
          state_d = ra_q ? S_FSTART : S_DONE;
          post_d  = ra_q;
        end else if (stat_i.split_hit) begin
          cmd_o   = ffa_pkg::CMD_SPLIT_START;
          state_d = S_MVS;
        end else begin
          cmd_o = ffa_pkg::CMD_SCAN_STEP;
        end
      end
      S_MVS: begin
        if (stat_i.mv_busy) begin
          cmd_o = ffa_pkg::CMD_MOVE;
        end else begin
          cmd_o   = ffa_pkg::CMD_SPLIT_NEW;
          state_d = S_SPO;
        end
      end
      S_SPO: begin
        cmd_o   = ffa_pkg::CMD_SPLIT_OLD;
        state_d = ra_q ? S_FSTART : S_DONE;
        post_d  = ra_q;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o   = ffa_pkg::CMD_MUL;
          state_d = S_APP;
        end else begin
          cmd_o = ffa_pkg::CMD_DIV_STEP;
        end
      end
      S_APP: begin
        if (stat_i.app_fail) begin
          cmd_o   = ffa_pkg::CMD_RES_NOSPACE;
          state_d = S_DONE;
        end else begin
          cmd_o   = ffa_pkg::CMD_APPEND;
          state_d = ra_q ? S_FSTART : S_DONE;
          post_d  = ra_q;
        end
      end
      S_FSTART: begin
        cmd_o   = ffa_pkg::CMD_SCAN_START;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (stat_i.scan_end) begin
          state_d = S_DONE;
          if (!post_q) begin
            cmd_o = ra_q ? ffa_pkg::CMD_RES_NOTFOUND_RA : ffa_pkg::CMD_RES_NOTFOUND;
          end
        end else if (stat_i.find_hit) begin
          cmd_o   = ffa_pkg::CMD_FIND_HIT;
          state_d = S_FHIT;
        end else begin
          cmd_o = ffa_pkg::CMD_SCAN_STEP;
        end
      end
      S_FHIT: begin
        if (ra_q && !post_q) begin
          if (stat_i.cap_ge) begin
            cmd_o   = ffa_pkg::CMD_INPLACE;
            state_d = S_DONE;
          end else begin
            cmd_o   = ffa_pkg::CMD_SCAN_START;
            state_d = S_ACHK;
          end
        end else if (stat_i.cur_free) begin
          state_d = S_DONE;
          if (!post_q) begin
            cmd_o = ffa_pkg::CMD_RES_ALREADY;
          end
        end else begin
          cmd_o   = ffa_pkg::CMD_MARK_FREE;
          state_d = S_PRV;
        end
      end
      S_PRV: begin
        if (stat_i.f_zero) begin
          cmd_o   = ffa_pkg::CMD_WR_CUR;
          state_d = S_NRD;
        end else begin
          cmd_o   = ffa_pkg::CMD_PRV_RD;
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (stat_i.rd_free) begin
          cmd_o   = ffa_pkg::CMD_PRV_MERGE;
          state_d = S_MVP;
        end else begin
          cmd_o   = ffa_pkg::CMD_WR_CUR;
          state_d = S_NRD;
        end
      end
      S_MVP: begin
        if (stat_i.mv_busy) begin
          cmd_o = ffa_pkg::CMD_MOVE;
        end else begin
          state_d = S_NRD;
        end
      end
      S_NRD: begin
        if (stat_i.nxt_exists) begin
          cmd_o   = ffa_pkg::CMD_NXT_RD;
          state_d = S_NCHK;
        end else begin
          state_d = S_FEND;
        end
      end
      S_NCHK: begin
        if (stat_i.rd_free) begin
          cmd_o   = ffa_pkg::CMD_NXT_MERGE;
          state_d = S_MVN;
        end else begin
          state_d = S_FEND;
        end
      end
      S_MVN: begin
        if (stat_i.mv_busy) begin
          cmd_o = ffa_pkg::CMD_MOVE;
        end else begin
          state_d = S_FEND;
        end
      end
      S_FEND: begin
        state_d = S_DONE;
        if (!post_q) begin
          cmd_o = ffa_pkg::CMD_RES_OK0;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o   = ffa_pkg::CMD_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ra_q    <= 1'b0;
      post_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ra_q    <= ra_d;
      post_q  <= post_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp
// block table, entry move engine, chunk divider and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [ffa_pkg::InW-1:0]     s_axis_tdata,
  input  wire logic                        cfg_we_i,
  input  wire logic [ffa_pkg::GmW-1:0]     cfg_wdata_i,
  input  wire logic                        m_axis_tready,
  output logic                             m_axis_tvalid,
  output logic      [ffa_pkg::OutW-1:0]    m_axis_tdata,
  input  wire ffa_pkg::cmd_e               cmd_i,
  output ffa_pkg::dp_stat_t                stat_o
);

  localparam int AW = ffa_pkg::AddrW;
  localparam int CW = ffa_pkg::CntW;
  localparam int SW = ffa_pkg::SizeW;
  localparam int OW = ffa_pkg::OffW;
  localparam int GW = ffa_pkg::GmW;
  localparam int KW = ffa_pkg::ChunkW;
  localparam logic [GW-1:0] Hdr = GW'(ffa_pkg::HeaderBytes);

  // control registers
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [GW-1:0]              top_q, top_d;
  logic [GW-1:0]              gm_q, gm_d;
  logic                       out_valid_q, out_valid_d;
  logic                       mv_pend_q, mv_pend_d;
  logic [CW-1:0]              mv_left_q, mv_left_d;
  logic [ffa_pkg::DivCntW-1:0] dcnt_q, dcnt_d;

  // payload registers
  ffa_pkg::op_e     op_q, op_d;
  logic [SW-1:0]    size_q, size_d;
  logic [OW-1:0]    boff_q, boff_d;
  logic [CW-1:0]    i_q, i_d;
  logic [AW-1:0]    f_q, f_d;
  ffa_pkg::entry_t  cur_q, cur_d;
  logic [GW-1:0]    rem_q, rem_d;
  logic [GW-1:0]    quo_q, quo_d;
  logic [KW-1:0]    chunk_q, chunk_d;
  logic [CW-1:0]    mv_src_q, mv_src_d;
  logic [AW-1:0]    mv_dst_q, mv_dst_d;
  logic             mv_up_q, mv_up_d;
  logic [OW-1:0]    res_off_q, res_off_d;
  ffa_pkg::status_e res_st_q, res_st_d;
  logic [OW-1:0]    out_off_q, out_off_d;
  ffa_pkg::status_e out_st_q, out_st_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_wa;
  ffa_pkg::entry_t            ram_wd;
  logic [AW-1:0]              ram_ra;
  logic [ffa_pkg::EntryW-1:0] ram_rdata;
  ffa_pkg::entry_t            rd;

  logic [GW-1:0]   need;
  logic [GW-1:0]   slack;
  logic [CW-1:0]   f_plus1;
  logic [GW:0]     div_t;
  logic            div_ge;
  logic [KW:0]     top_sum;
  logic [GW-1:0]   split_start;
  ffa_pkg::entry_t merged;

  ffa_ram #(
    .Width(ffa_pkg::EntryW),
    .Depth(ffa_pkg::MaxBlocks)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(ram_ra),
    .rdata_o(ram_rdata)
  );

  assign rd          = ffa_pkg::entry_t'(ram_rdata);
  assign need        = {1'b0, size_q} + Hdr;
  assign slack       = {1'b0, rd.capacity} - {1'b0, rd.used};
  assign f_plus1     = {1'b0, f_q} + CW'(1);
  assign div_t       = {rem_q, quo_q[GW-1]};
  assign div_ge      = div_t >= {1'b0, gm_q};
  assign top_sum     = (KW+1)'(top_q) + {1'b0, chunk_q};
  assign split_start = {1'b0, cur_q.start} + Hdr + {1'b0, cur_q.used};

  always_comb begin
    stat_o.op         = op_q;
    stat_o.size_zero  = size_q == '0;
    stat_o.boff_none  = boff_q == ffa_pkg::NoBlock;
    stat_o.scan_end   = i_q == cnt_q;
    stat_o.reuse_hit  = rd.is_free && (rd.capacity >= size_q);
    stat_o.split_hit  = (cnt_q < CW'(ffa_pkg::MaxBlocks)) && (rd.used <= rd.capacity) &&
                        (slack >= need);
    stat_o.find_hit   = ({1'b0, rd.start} + Hdr) == {1'b0, boff_q};
    stat_o.cur_free   = cur_q.is_free;
    stat_o.cap_ge     = cur_q.capacity >= size_q;
    stat_o.f_zero     = f_q == '0;
    stat_o.rd_free    = rd.is_free;
    stat_o.nxt_exists = f_plus1 < cnt_q;
    stat_o.mv_busy    = (mv_left_q != '0) || mv_pend_q;
    stat_o.div_done   = dcnt_q == '0;
    stat_o.app_fail   = (cnt_q >= CW'(ffa_pkg::MaxBlocks)) ||
                        (top_sum > (KW+1)'(ffa_pkg::HeapBytes));
    stat_o.out_free   = !out_valid_q || m_axis_tready;
  end

  always_comb begin
    cnt_d       = cnt_q;
    top_d       = top_q;
    gm_d        = gm_q;
    out_valid_d = out_valid_q;
    mv_pend_d   = mv_pend_q;
    mv_left_d   = mv_left_q;
    dcnt_d      = dcnt_q;
    op_d        = op_q;
    size_d      = size_q;
    boff_d      = boff_q;
    i_d         = i_q;
    f_d         = f_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    chunk_d     = chunk_q;
    mv_src_d    = mv_src_q;
    mv_dst_d    = mv_dst_q;
    mv_up_d     = mv_up_q;
    res_off_d   = res_off_q;
    res_st_d    = res_st_q;
    out_off_d   = out_off_q;
    out_st_d    = out_st_q;
    ram_we      = 1'b0;
    ram_wa      = f_q;
    ram_wd      = cur_q;
    ram_ra      = '0;
    merged      = cur_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i && (cfg_wdata_i != '0)) begin
      gm_d = (cfg_wdata_i < GW'(2 * ffa_pkg::HeaderBytes)) ? GW'(ffa_pkg::GmLowVal)
                                                          : cfg_wdata_i;
    end

    case (cmd_i)
      ffa_pkg::CMD_LOAD: begin
        op_d   = ffa_pkg::op_e'(s_axis_tdata[1:0]);
        size_d = s_axis_tdata[SW+1:2];
        boff_d = s_axis_tdata[SW+OW+1:SW+2];
      end
      ffa_pkg::CMD_RESET_HEAP: begin
        cnt_d     = '0;
        top_d     = '0;
        res_off_d = '0;
        res_st_d  = ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_RES_NULL: begin
        res_off_d = '0;
        res_st_d  = ffa_pkg::ST_NULL;
      end
      ffa_pkg::CMD_SCAN_START: begin
        i_d    = '0;
        ram_ra = '0;
      end
      ffa_pkg::CMD_SCAN_STEP: begin
        i_d    = i_q + CW'(1);
        ram_ra = i_d[AW-1:0];
      end
      ffa_pkg::CMD_REUSE: begin
        ram_we         = 1'b1;
        ram_wa         = i_q[AW-1:0];
        ram_wd         = rd;
        ram_wd.is_free = 1'b0;
        ram_wd.used    = size_q;
        res_off_d      = OW'({1'b0, rd.start} + Hdr);
        res_st_d       = ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_SPLIT_START: begin
        cur_d     = rd;
        f_d       = i_q[AW-1:0];
        mv_src_d  = cnt_q - CW'(1);
        mv_left_d = cnt_q - i_q - CW'(1);
        mv_up_d   = 1'b1;
        mv_pend_d = 1'b0;
        cnt_d     = cnt_q + CW'(1);
      end
      ffa_pkg::CMD_MOVE: begin
        if (mv_pend_q) begin
          ram_we = 1'b1;
          ram_wa = mv_dst_q;
          ram_wd = rd;
        end
        if (mv_left_q != '0) begin
          ram_ra    = mv_src_q[AW-1:0];
          mv_dst_d  = mv_up_q ? AW'(mv_src_q + CW'(1)) : AW'(mv_src_q - CW'(1));
          mv_src_d  = mv_up_q ? mv_src_q - CW'(1) : mv_src_q + CW'(1);
          mv_left_d = mv_left_q - CW'(1);
          mv_pend_d = 1'b1;
        end else begin
          mv_pend_d = 1'b0;
        end
      end
      ffa_pkg::CMD_SPLIT_NEW: begin
        ram_we          = 1'b1;
        ram_wa          = f_plus1[AW-1:0];
        ram_wd.is_free  = 1'b0;
        ram_wd.start    = split_start[OW-1:0];
        ram_wd.capacity = SW'(cur_q.capacity - cur_q.used - SW'(ffa_pkg::HeaderBytes));
        ram_wd.used     = size_q;
        res_off_d       = OW'(split_start + Hdr);
        res_st_d        = ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_SPLIT_OLD: begin
        ram_we          = 1'b1;
        ram_wd.capacity = cur_q.used;
      end
      ffa_pkg::CMD_DIV_START: begin
        rem_d  = '0;
        quo_d  = need;
        dcnt_d = ffa_pkg::DivCntW'(GW);
      end
      ffa_pkg::CMD_DIV_STEP: begin
        rem_d  = div_ge ? GW'(div_t - {1'b0, gm_q}) : div_t[GW-1:0];
        quo_d  = {quo_q[GW-2:0], div_ge};
        dcnt_d = dcnt_q - ffa_pkg::DivCntW'(1);
      end
      ffa_pkg::CMD_MUL: begin
        chunk_d = KW'({1'b0, quo_q} + (GW+1)'(1)) * KW'(gm_q);
      end
      ffa_pkg::CMD_APPEND: begin
        ram_we          = 1'b1;
        ram_wa          = cnt_q[AW-1:0];
        ram_wd.is_free  = 1'b0;
        ram_wd.start    = top_q[OW-1:0];
        ram_wd.capacity = SW'(chunk_q - KW'(ffa_pkg::HeaderBytes));
        ram_wd.used     = size_q;
        cnt_d           = cnt_q + CW'(1);
        top_d           = top_sum[GW-1:0];
        res_off_d       = OW'(top_q + Hdr);
        res_st_d        = ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_RES_NOSPACE: begin
        res_off_d = '0;
        res_st_d  = ffa_pkg::ST_NO_SPACE;
      end
      ffa_pkg::CMD_FIND_HIT: begin
        cur_d = rd;
        f_d   = i_q[AW-1:0];
      end
      ffa_pkg::CMD_RES_NOTFOUND: begin
        res_off_d = '0;
        res_st_d  = ffa_pkg::ST_NOT_FOUND;
      end
      ffa_pkg::CMD_RES_NOTFOUND_RA: begin
        res_off_d = boff_q;
        res_st_d  = ffa_pkg::ST_NOT_FOUND;
      end
      ffa_pkg::CMD_RES_ALREADY: begin
        res_off_d = '0;
        res_st_d  = ffa_pkg::ST_ALREADY_FREE;
      end
      ffa_pkg::CMD_INPLACE: begin
        ram_we         = 1'b1;
        ram_wd.is_free = 1'b0;
        ram_wd.used    = size_q;
        res_off_d      = boff_q;
        res_st_d       = ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_MARK_FREE: begin
        cur_d.is_free = 1'b1;
        cur_d.used    = '0;
      end
      ffa_pkg::CMD_WR_CUR: begin
        ram_we = 1'b1;
      end
      ffa_pkg::CMD_PRV_RD: begin
        ram_ra = f_q - AW'(1);
      end
      ffa_pkg::CMD_PRV_MERGE: begin
        merged          = rd;
        merged.capacity = SW'(rd.capacity + cur_q.capacity + SW'(ffa_pkg::HeaderBytes));
        cur_d           = merged;
        ram_we          = 1'b1;
        ram_wa          = f_q - AW'(1);
        ram_wd          = merged;
        mv_src_d        = f_plus1;
        mv_left_d       = cnt_q - f_plus1;
        mv_up_d         = 1'b0;
        mv_pend_d       = 1'b0;
        cnt_d           = cnt_q - CW'(1);
        f_d             = f_q - AW'(1);
      end
      ffa_pkg::CMD_NXT_RD: begin
        ram_ra = f_plus1[AW-1:0];
      end
      ffa_pkg::CMD_NXT_MERGE: begin
        merged.capacity = SW'(cur_q.capacity + rd.capacity + SW'(ffa_pkg::HeaderBytes));
        cur_d           = merged;
        ram_we          = 1'b1;
        ram_wd          = merged;
        mv_src_d        = f_plus1 + CW'(1);
        mv_left_d       = cnt_q - f_plus1 - CW'(1);
        mv_up_d         = 1'b0;
        mv_pend_d       = 1'b0;
        cnt_d           = cnt_q - CW'(1);
      end
      ffa_pkg::CMD_RES_OK0: begin
        res_off_d = '0;
        res_st_d  = ffa_pkg::ST_OK;
      end
      ffa_pkg::CMD_OUT: begin
        out_valid_d = 1'b1;
        out_off_d   = res_off_q;
        out_st_d    = res_st_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      top_q       <= '0;
      gm_q        <= ffa_pkg::GmReset;
      out_valid_q <= 1'b0;
      mv_pend_q   <= 1'b0;
      mv_left_q   <= '0;
      dcnt_q      <= '0;
    end else begin
      cnt_q       <= cnt_d;
      top_q       <= top_d;
      gm_q        <= gm_d;
      out_valid_q <= out_valid_d;
      mv_pend_q   <= mv_pend_d;
      mv_left_q   <= mv_left_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    size_q    <= size_d;
    boff_q    <= boff_d;
    i_q       <= i_d;
    f_q       <= f_d;
    cur_q     <= cur_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    chunk_q   <= chunk_d;
    mv_src_q  <= mv_src_d;
    mv_dst_q  <= mv_dst_d;
    mv_up_q   <= mv_up_d;
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
    out_off_q <= out_off_d;
    out_st_q  <= out_st_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(ffa_pkg::OutW - OW - ffa_pkg::StW)'(0), out_st_q, out_off_q};

endmodule

`default_nettype wire
